// File: sv/rwh_pkg.sv
// rwh_pkg: shared constants, register indexes, controller states and the
// command/status structs of the rolling window hash unit
// no dependencies
`default_nettype none

package rwh_pkg;

    // hash arithmetic
    localparam int          HASH_W       = 25;
    localparam logic [24:0] BIG_PRIME    = 25'd32000011;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 25;
    localparam int WIN_LEN_W  = 7;
    localparam int SHIFT_W    = 4;

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LEN  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SHIFT_BITS  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BUCKET_MOD  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DROP_FACTOR = 3'd3;

    localparam logic [WIN_LEN_W-1:0] RST_WINDOW_LEN  = 7'd4;
    localparam logic [SHIFT_W-1:0]   RST_SHIFT_BITS  = 4'd1;
    localparam logic [HASH_W-1:0]    RST_BUCKET_MOD  = 25'd20011;
    localparam logic [HASH_W-1:0]    RST_DROP_FACTOR = 25'd8;

    // parameter defaults
    localparam int DEF_MAX_WINDOW  = 64;
    localparam int DEF_SYMBOL_BITS = 8;

    // step counter: holds HASH_W, symbol bits (<= 31) and shift amount
    localparam int CNT_W = $clog2(HASH_W + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DROP,
        ST_SUB,
        ST_SHIFT,
        ST_ADD,
        ST_BUCKET,
        ST_DONE
    } rwh_state_t;

    typedef struct packed {
        logic capture;
        logic fetch;
        logic drop_step;
        logic drop_sub;
        logic shift_step;
        logic add_term;
        logic bucket_step;
        logic out_load;
    } rwh_cmd_t;

    typedef struct packed {
        logic               full;
        logic [SHIFT_W-1:0] shift_amt;
        logic               out_free;
    } rwh_status_t;

endpackage

`default_nettype wire

// File: sv/rwh_ctrl.sv
// rwh_ctrl: sequencer of the rolling window hash unit, steps the bit-serial
// datapath through drop, shift, add and bucket phases
// depends on rwh_pkg
`default_nettype none

module rwh_ctrl #(
    parameter int SYMBOL_BITS = rwh_pkg::DEF_SYMBOL_BITS
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire rwh_pkg::rwh_status_t status,
    output rwh_pkg::rwh_cmd_t         cmd
);

    rwh_pkg::rwh_state_t state_reg, state_next;
    logic [rwh_pkg::CNT_W-1:0] cnt_reg, cnt_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= rwh_pkg::ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            rwh_pkg::ST_IDLE: begin
                if (s_valid) state_next = rwh_pkg::ST_CHECK;
            end
            rwh_pkg::ST_CHECK: begin
                state_next = status.full ? rwh_pkg::ST_DROP : rwh_pkg::ST_SHIFT;
            end
            rwh_pkg::ST_DROP: begin
                if (cnt_reg == rwh_pkg::CNT_W'(1)) state_next = rwh_pkg::ST_SUB;
            end
            rwh_pkg::ST_SUB: begin
                state_next = rwh_pkg::ST_SHIFT;
            end
            rwh_pkg::ST_SHIFT: begin
                if (cnt_reg == '0) state_next = rwh_pkg::ST_ADD;
            end
            rwh_pkg::ST_ADD: begin
                state_next = rwh_pkg::ST_BUCKET;
            end
            rwh_pkg::ST_BUCKET: begin
                if (cnt_reg == rwh_pkg::CNT_W'(1)) state_next = rwh_pkg::ST_DONE;
            end
            rwh_pkg::ST_DONE: begin
                if (status.out_free) state_next = rwh_pkg::ST_IDLE;
            end
            default: state_next = rwh_pkg::ST_IDLE;
        endcase
    end

    // commands
    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        unique case (state_reg)
            rwh_pkg::ST_IDLE: begin
                s_ready     = 1'b1;
                cmd.capture = s_valid;
            end
            rwh_pkg::ST_CHECK:  cmd.fetch       = status.full;
            rwh_pkg::ST_DROP:   cmd.drop_step   = 1'b1;
            rwh_pkg::ST_SUB:    cmd.drop_sub    = 1'b1;
            rwh_pkg::ST_SHIFT:  cmd.shift_step  = (cnt_reg != '0);
            rwh_pkg::ST_ADD:    cmd.add_term    = 1'b1;
            rwh_pkg::ST_BUCKET: cmd.bucket_step = 1'b1;
            rwh_pkg::ST_DONE:   cmd.out_load    = status.out_free;
            default: cmd = '0;
        endcase
    end

    // step counter
    always_comb begin
        cnt_next = cnt_reg;
        unique case (state_reg) inside
            rwh_pkg::ST_CHECK: begin
                cnt_next = status.full ? rwh_pkg::CNT_W'(SYMBOL_BITS)
                                       : rwh_pkg::CNT_W'(status.shift_amt);
            end
            rwh_pkg::ST_SUB:    cnt_next = rwh_pkg::CNT_W'(status.shift_amt);
            rwh_pkg::ST_ADD:    cnt_next = rwh_pkg::CNT_W'(rwh_pkg::HASH_W);
            rwh_pkg::ST_DROP,
            rwh_pkg::ST_BUCKET: cnt_next = cnt_reg - rwh_pkg::CNT_W'(1);
            rwh_pkg::ST_SHIFT: begin
                if (cnt_reg != '0) cnt_next = cnt_reg - rwh_pkg::CNT_W'(1);
            end
            default: cnt_next = cnt_reg;
        endcase
    end

endmodule

`default_nettype wire

// File: sv/rwh_datapath.sv
// rwh_datapath: configuration registers, symbol window memory, running hash,
// bit-serial modular multiply and bucket remainder units, result register
// depends on rwh_pkg
`default_nettype none

module rwh_datapath #(
    parameter int MAX_WINDOW  = rwh_pkg::DEF_MAX_WINDOW,
    parameter int SYMBOL_BITS = rwh_pkg::DEF_SYMBOL_BITS
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             cfg_valid,
    input  wire logic [rwh_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [rwh_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  wire logic [SYMBOL_BITS-1:0]           s_symbol,
    input  wire logic                             s_start_word,
    input  wire rwh_pkg::rwh_cmd_t                cmd,
    output rwh_pkg::rwh_status_t                  status,
    input  wire logic                             m_ready,
    output logic                                  m_valid,
    output logic                                  m_hash_valid,
    output logic [rwh_pkg::HASH_W-1:0]            m_big_hash,
    output logic [rwh_pkg::HASH_W-1:0]            m_bucket
);

    localparam int HW = rwh_pkg::HASH_W;
    localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int LW = $clog2(MAX_WINDOW + 1);
    localparam int DW = LW + 1;

    localparam logic [HW:0] PRIME_X = {1'b0, rwh_pkg::BIG_PRIME};

    // configuration
    logic [rwh_pkg::WIN_LEN_W-1:0] win_len_reg;
    logic [rwh_pkg::SHIFT_W-1:0]   shift_bits_reg;
    logic [HW-1:0]                 bucket_mod_reg;
    logic [HW-1:0]                 drop_factor_reg;

    // window and hash state
    logic [SYMBOL_BITS-1:0] win_mem [MAX_WINDOW];
    logic [AW-1:0]          wp_reg;
    logic [LW-1:0]          seen_reg;
    logic [HW-1:0]          hash_reg, hash_next;
    logic                   full_reg;
    logic                   hv_reg;
    logic [SYMBOL_BITS-1:0] sym_reg;
    logic [SYMBOL_BITS-1:0] rd_reg;
    logic [SYMBOL_BITS-1:0] term_sr_reg;
    logic [HW-1:0]          acc_reg;
    logic [HW-1:0]          div_sr_reg;
    logic [HW-1:0]          rem_reg;

    // result register
    logic          m_valid_reg;
    logic          m_hash_valid_reg;
    logic [HW-1:0] m_big_hash_reg;
    logic [HW-1:0] m_bucket_reg;

    logic [LW-1:0]          len_eff;
    logic [DW-1:0]          wp_x, len_x, ra_x;
    logic [AW-1:0]          rd_addr;
    logic [AW-1:0]          wp_inc;
    logic [LW-1:0]          seen_next;
    logic [SYMBOL_BITS-1:0] term_new, term_old;
    logic [HW-1:0]          df_eff;
    logic [HW:0]            acc_dbl, acc_sum;
    logic [HW-1:0]          acc_dbl_red, acc_next;
    logic [HW:0]            h_dbl, h_sum, h_drop;
    logic [HW-1:0]          h_dbl_red, h_sum_red;
    logic [HW:0]            rem_sh, rem_sub, mod_x;
    logic [HW-1:0]          rem_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_len_reg     <= rwh_pkg::RST_WINDOW_LEN;
            shift_bits_reg  <= rwh_pkg::RST_SHIFT_BITS;
            bucket_mod_reg  <= rwh_pkg::RST_BUCKET_MOD;
            drop_factor_reg <= rwh_pkg::RST_DROP_FACTOR;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                rwh_pkg::REG_WINDOW_LEN:  win_len_reg     <= cfg_data[rwh_pkg::WIN_LEN_W-1:0];
                rwh_pkg::REG_SHIFT_BITS:  shift_bits_reg  <= cfg_data[rwh_pkg::SHIFT_W-1:0];
                rwh_pkg::REG_BUCKET_MOD:  bucket_mod_reg  <= cfg_data[HW-1:0];
                rwh_pkg::REG_DROP_FACTOR: drop_factor_reg <= cfg_data[HW-1:0];
                default: ;
            endcase
        end
    end

    // window length clamped to 1..MAX_WINDOW
    always_comb begin
        if (win_len_reg == '0)
            len_eff = LW'(1);
        else if (int'(win_len_reg) > MAX_WINDOW)
            len_eff = LW'(MAX_WINDOW);
        else
            len_eff = LW'(win_len_reg);
    end

    // oldest symbol of the window sits len_eff writes behind the write pointer
    assign wp_x    = DW'(wp_reg);
    assign len_x   = DW'(len_eff);
    assign ra_x    = (wp_x >= len_x) ? (wp_x - len_x)
                                     : (wp_x + DW'(MAX_WINDOW) - len_x);
    assign rd_addr = ra_x[AW-1:0];
    assign wp_inc  = (int'(wp_reg) == MAX_WINDOW - 1) ? '0 : wp_reg + AW'(1);

    assign seen_next = s_start_word ? LW'(1)
                     : ((int'(seen_reg) == MAX_WINDOW) ? seen_reg : seen_reg + LW'(1));

    // symbol memory, read before write on the same request
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            win_mem[wp_reg] <= s_symbol;
            rd_reg          <= win_mem[rd_addr];
            sym_reg         <= s_symbol;
        end
    end

    assign term_new = (sym_reg == '0) ? '0 : sym_reg - SYMBOL_BITS'(1);
    assign term_old = (rd_reg == '0) ? '0 : rd_reg - SYMBOL_BITS'(1);

    // drop term: (oldest - 1) * drop_factor mod P, one multiplier bit a cycle
    assign df_eff      = (drop_factor_reg >= rwh_pkg::BIG_PRIME)
                       ? drop_factor_reg - rwh_pkg::BIG_PRIME : drop_factor_reg;
    assign acc_dbl     = {acc_reg, 1'b0};
    assign acc_dbl_red = (acc_dbl >= PRIME_X) ? HW'(acc_dbl - PRIME_X) : acc_dbl[HW-1:0];
    assign acc_sum     = {1'b0, acc_dbl_red}
                       + (term_sr_reg[SYMBOL_BITS-1] ? {1'b0, df_eff} : '0);
    assign acc_next    = (acc_sum >= PRIME_X) ? HW'(acc_sum - PRIME_X) : acc_sum[HW-1:0];

    // hash updates
    assign h_dbl     = {hash_reg, 1'b0};
    assign h_dbl_red = (h_dbl >= PRIME_X) ? HW'(h_dbl - PRIME_X) : h_dbl[HW-1:0];
    assign h_sum     = {1'b0, hash_reg} + (HW + 1)'(term_new);
    assign h_sum_red = (h_sum >= PRIME_X) ? HW'(h_sum - PRIME_X) : h_sum[HW-1:0];
    assign h_drop    = (hash_reg >= acc_reg) ? {1'b0, hash_reg - acc_reg}
                                             : {1'b0, hash_reg} + PRIME_X - {1'b0, acc_reg};

    always_comb begin
        hash_next = hash_reg;
        if (cmd.capture && s_start_word) hash_next = '0;
        if (cmd.drop_sub)                hash_next = h_drop[HW-1:0];
        if (cmd.shift_step)              hash_next = h_dbl_red;
        if (cmd.add_term)                hash_next = h_sum_red;
    end

    // bucket: restoring remainder, one dividend bit a cycle
    assign mod_x    = {1'b0, bucket_mod_reg};
    assign rem_sh   = {rem_reg, div_sr_reg[HW-1]};
    assign rem_sub  = rem_sh - mod_x;
    assign rem_next = (rem_sh >= mod_x) ? rem_sub[HW-1:0] : rem_sh[HW-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg   <= '0;
            seen_reg <= '0;
            hash_reg <= '0;
            full_reg <= 1'b0;
        end else begin
            hash_reg <= hash_next;
            if (cmd.capture) begin
                wp_reg   <= wp_inc;
                seen_reg <= seen_next;
                full_reg <= !s_start_word && (seen_reg >= len_eff);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            hv_reg  <= (seen_next >= len_eff);
            acc_reg <= '0;
        end
        if (cmd.fetch)     term_sr_reg <= term_old;
        if (cmd.drop_step) begin
            acc_reg     <= acc_next;
            term_sr_reg <= {term_sr_reg[SYMBOL_BITS-2:0], 1'b0};
        end
        if (cmd.add_term) begin
            div_sr_reg <= h_sum_red;
            rem_reg    <= '0;
        end
        if (cmd.bucket_step) begin
            rem_reg    <= rem_next;
            div_sr_reg <= {div_sr_reg[HW-2:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_hash_valid_reg <= hv_reg;
            m_big_hash_reg   <= hash_reg;
            m_bucket_reg     <= (bucket_mod_reg == '0) ? hash_reg : rem_reg;
        end
    end

    assign status.full      = full_reg;
    assign status.shift_amt = shift_bits_reg;
    assign status.out_free  = !m_valid_reg || m_ready;

    assign m_valid      = m_valid_reg;
    assign m_hash_valid = m_hash_valid_reg;
    assign m_big_hash   = m_big_hash_reg;
    assign m_bucket     = m_bucket_reg;

endmodule

`default_nettype wire

// File: sv/rolling_window_hash_unit.sv
// sequence: capture, then once the window is full a bit-serial drop multiply,
// one doubling per shift bit, the term add and a 25-step bucket remainder; the
// next request can be taken in the cycle after the result register is loaded,
// while that result may still wait downstream
// reset: synchronous active-low aresetn clears hash, fill count, handshakes and
// loads default register values; the symbol memory needs no clearing
`default_nettype none

module rolling_window_hash_unit #(
    parameter int MAX_WINDOW  = rwh_pkg::DEF_MAX_WINDOW,
    parameter int SYMBOL_BITS = rwh_pkg::DEF_SYMBOL_BITS
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [rwh_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [rwh_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic [SYMBOL_BITS-1:0]         s_symbol,
    input  wire logic                           s_start_word,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic                                m_hash_valid,
    output logic [rwh_pkg::HASH_W-1:0]          m_big_hash,
    output logic [rwh_pkg::HASH_W-1:0]          m_bucket
);

    rwh_pkg::rwh_cmd_t    cmd;
    rwh_pkg::rwh_status_t status;

    assign cfg_ready = 1'b1;

    rwh_ctrl #(
        .SYMBOL_BITS (SYMBOL_BITS)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    rwh_datapath #(
        .MAX_WINDOW  (MAX_WINDOW),
        .SYMBOL_BITS (SYMBOL_BITS)
    ) u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_valid    (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_symbol     (s_symbol),
        .s_start_word (s_start_word),
        .cmd          (cmd),
        .status       (status),
        .m_ready      (m_ready),
        .m_valid      (m_valid),
        .m_hash_valid (m_hash_valid),
        .m_big_hash   (m_big_hash),
        .m_bucket     (m_bucket)
    );

    // one request in flight at a time
    a_one_request: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("request taken while another is in progress");

    // never overwrite a result that has not been taken
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_valid || m_ready))
        else $error("result register overwritten");

    a_one_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(cmd))
        else $error("more than one datapath command at once");

    a_hash_reduced: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_big_hash < rwh_pkg::BIG_PRIME))
        else $error("hash not reduced below the prime");

endmodule

`default_nettype wire
